// ===== sv/whole_word_keyword_counter_defines.svh =====
// assertion macros for the keyword counter module
`ifndef WHOLE_WORD_KEYWORD_COUNTER_DEFINES_SVH
`define WHOLE_WORD_KEYWORD_COUNTER_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define WWKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define WWKC_ASSERT_NEVER(label, cond, msg) \
  `WWKC_ASSERT(label, !(cond), msg)

`endif

// ===== sv/wwkc_pkg.sv =====
// types, codes and character helpers for the keyword counter
package wwkc_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned CntW      = 8;
  localparam int unsigned LineW     = 16;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned OutTdataW = 40;
  localparam logic [CntW-1:0] CntMax = 8'hFF;

  // input command codes carried on tuser
  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_KEY_CHAR = 3'd1,
    CMD_KEY_END  = 3'd2,
    CMD_TEXT     = 3'd3,
    CMD_LINE_END = 3'd4
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_LCHK,
    S_CHR,
    S_CTAIL,
    S_EMIT
  } state_e;

  // ascii letter test
  function automatic logic is_letter(input logic [CharW-1:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // fold upper case letters to lower case
  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      fold = c + 8'd32;
    end else begin
      fold = c;
    end
  endfunction

endpackage

// ===== sv/wwkc_ram.sv =====
// generic simple dual port ram with registered read
module wwkc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/whole_word_keyword_counter.sv =====
// Whole-word keyword counter: keyword store, word buffer and match sequencer.
// Input channel s_axis: tuser carries the command (clear set, keyword char,
// keyword end, text char, line end), tdata the character byte.
// Output channel m_axis: one item per line end with the line number, the
// line's match count, the running maximum of the set and an at-maximum flag.
// Keyword and text characters are taken in the idle step. A word end (a non-letter
// text char or a line end) walks the stored keywords one after another through
// the keyword length and keyword character memories: each keyword gets a length
// read (S_LEN) and check (S_LCHK), and one of equal length then also a
// character pass (S_CHR) and a final compare (S_CTAIL) before the next keyword.
// A line end then goes to the emit step, which loads the output register.
// One item is worked on at a time; the output register holds a finished result
// while the next items are taken. If the receiver stalls and a second line
// result is ready, the block waits in its emit step with input ready low.
// Reset empties the keyword set, clears the counters and the output valid;
// no memory clearing pass is needed.
module whole_word_keyword_counter
  import wwkc_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 32,
  parameter int unsigned KEY_LEN   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [CharW-1:0]     s_axis_tdata_i,  // [7:0] char_code
  input  logic [CmdW-1:0]      s_axis_tuser_i,  // [2:0] cmd
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [15:0] line_number, [23:16] match_count, [31:24] running_max, [32] at_max
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  `include "whole_word_keyword_counter_defines.svh"

  localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned TW = $clog2(KEY_COUNT + 1);
  localparam int unsigned LW = $clog2(KEY_LEN);
  localparam int unsigned FW = $clog2(KEY_LEN + 1);
  localparam int unsigned CDEPTH = KEY_COUNT * KEY_LEN;
  localparam int unsigned AW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  state_e          state_q, state_d;
  logic [TW-1:0]   total_q, total_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   wlen_q, wlen_d;
  logic            wlong_q, wlong_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] max_q, max_d;
  logic [LineW-1:0] line_q, line_d;
  logic [KW-1:0]   k_q, k_d;
  logic [LW-1:0]   i_q, i_d;
  logic            pend_q, pend_d;
  logic            mism_q, mism_d;
  logic            le_q, le_d;
  logic            m_valid_q, m_valid_d;

  logic [LineW-1:0] out_line_q;
  logic [CntW-1:0]  out_cnt_q;
  logic [CntW-1:0]  out_max_q;
  logic             out_at_max_q;
  logic             out_load;
  logic [CntW-1:0]  new_max;

  logic            in_fire;
  cmd_e            cmd;
  logic [CharW-1:0] ch;
  logic            key_more;
  logic            chr_ne;
  logic            scan_go;

  logic            kw_we;
  logic [AW-1:0]   kw_waddr, kw_raddr;
  logic [CharW-1:0] kw_rdata;
  logic            len_we;
  logic [FW-1:0]   len_rdata;
  logic            wd_we;
  logic [CharW-1:0] wd_rdata;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign ch      = s_axis_tdata_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // keyword character store, one row of KEY_LEN per keyword
  assign kw_waddr = AW'(total_q[KW-1:0]) * AW'(KEY_LEN) + AW'(fill_q[LW-1:0]);
  assign kw_raddr = AW'(k_q) * AW'(KEY_LEN) + AW'(i_q);

  wwkc_ram #(.WIDTH(CharW), .DEPTH(CDEPTH)) u_kw_chars (
    .clk_i   (clk_i),
    .we_i    (kw_we),
    .waddr_i (kw_waddr),
    .wdata_i (fold(ch)),
    .raddr_i (kw_raddr),
    .rdata_o (kw_rdata)
  );

  // keyword length store
  wwkc_ram #(.WIDTH(FW), .DEPTH(KEY_COUNT)) u_kw_lens (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (total_q[KW-1:0]),
    .wdata_i (fill_q),
    .raddr_i (k_q),
    .rdata_o (len_rdata)
  );

  // letters of the current word
  wwkc_ram #(.WIDTH(CharW), .DEPTH(KEY_LEN)) u_word (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wlen_q[LW-1:0]),
    .wdata_i (fold(ch)),
    .raddr_i (i_q),
    .rdata_o (wd_rdata)
  );

  // compare helpers
  assign key_more = ({1'b0, TW'(k_q)} + (TW+1)'(1)) < {1'b0, total_q};
  assign chr_ne   = (kw_rdata != wd_rdata);
  assign scan_go  = (wlen_q != '0) && !wlong_q && (total_q != '0);
  assign new_max  = (cnt_q > max_q) ? cnt_q : max_q;

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    fill_d    = fill_q;
    wlen_d    = wlen_q;
    wlong_d   = wlong_q;
    cnt_d     = cnt_q;
    max_d     = max_q;
    line_d    = line_q;
    k_d       = k_q;
    i_d       = i_q;
    pend_d    = pend_q;
    mism_d    = mism_q;
    le_d      = le_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    kw_we     = 1'b0;
    len_we    = 1'b0;
    wd_we     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_CLEAR: begin
              total_d = '0;
              fill_d  = '0;
              wlen_d  = '0;
              wlong_d = 1'b0;
              cnt_d   = '0;
              max_d   = '0;
              line_d  = '0;
            end
            CMD_KEY_CHAR: begin
              if ((total_q < TW'(KEY_COUNT)) && (fill_q < FW'(KEY_LEN))) begin
                kw_we  = 1'b1;
                fill_d = fill_q + FW'(1);
              end
            end
            CMD_KEY_END: begin
              if (total_q < TW'(KEY_COUNT)) begin
                len_we  = 1'b1;
                total_d = total_q + TW'(1);
              end
              fill_d = '0;
            end
            CMD_TEXT, CMD_LINE_END: begin
              if ((cmd == CMD_TEXT) && is_letter(ch)) begin
                if (wlen_q < FW'(KEY_LEN)) begin
                  wd_we  = 1'b1;
                  wlen_d = wlen_q + FW'(1);
                end else begin
                  wlong_d = 1'b1;
                end
              end else if (scan_go) begin
                k_d     = '0;
                le_d    = (cmd == CMD_LINE_END);
                state_d = S_LEN;
              end else begin
                wlen_d  = '0;
                wlong_d = 1'b0;
                state_d = (cmd == CMD_LINE_END) ? S_EMIT : S_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        state_d = S_LCHK;
      end
      S_LCHK: begin
        pend_d = 1'b0;
        mism_d = 1'b0;
        i_d    = '0;
        if (len_rdata == wlen_q) begin
          state_d = S_CHR;
        end else if (key_more) begin
          k_d     = k_q + KW'(1);
          state_d = S_LEN;
        end else begin
          wlen_d  = '0;
          wlong_d = 1'b0;
          state_d = le_q ? S_EMIT : S_IDLE;
        end
      end
      S_CHR: begin
        pend_d = 1'b1;
        if (pend_q && chr_ne) begin
          mism_d = 1'b1;
        end
        if ((FW'(i_q) + FW'(1)) == wlen_q) begin
          state_d = S_CTAIL;
        end else begin
          i_d = i_q + LW'(1);
        end
      end
      S_CTAIL: begin
        if (!(mism_q || chr_ne) && (cnt_q != CntMax)) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (key_more) begin
          k_d     = k_q + KW'(1);
          state_d = S_LEN;
        end else begin
          wlen_d  = '0;
          wlong_d = 1'b0;
          state_d = le_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          max_d     = new_max;
          line_d    = line_q + LineW'(1);
          cnt_d     = '0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      fill_q    <= '0;
      wlen_q    <= '0;
      wlong_q   <= 1'b0;
      cnt_q     <= '0;
      max_q     <= '0;
      line_q    <= '0;
      k_q       <= '0;
      i_q       <= '0;
      pend_q    <= 1'b0;
      mism_q    <= 1'b0;
      le_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      fill_q    <= fill_d;
      wlen_q    <= wlen_d;
      wlong_q   <= wlong_d;
      cnt_q     <= cnt_d;
      max_q     <= max_d;
      line_q    <= line_d;
      k_q       <= k_d;
      i_q       <= i_d;
      pend_q    <= pend_d;
      mism_q    <= mism_d;
      le_q      <= le_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_line_q   <= line_q;
      out_cnt_q    <= cnt_q;
      out_max_q    <= new_max;
      out_at_max_q <= (cnt_q == new_max);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_at_max_q, out_max_q, out_cnt_q, out_line_q};

  // checks
  `WWKC_ASSERT(a_at_max_eq, m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[23:16] == m_axis_tdata_o[31:24], "at_max set but count differs from maximum")
  `WWKC_ASSERT(a_max_ge_cnt, m_axis_tvalid_o |-> m_axis_tdata_o[31:24] >= m_axis_tdata_o[23:16], "running maximum below line count")
  `WWKC_ASSERT(a_line_step, out_load |=> line_q == $past(line_q) + 16'd1, "line counter did not advance on result")
  `WWKC_ASSERT_NEVER(a_key_range, (state_q != S_IDLE) && (state_q != S_EMIT) && ({1'b0, TW'(k_q)} >= {1'b0, total_q}), "keyword index beyond stored keywords")
  `WWKC_ASSERT(a_no_overwrite, m_axis_tvalid_o && !m_axis_tready_i |-> !out_load, "result register overwritten while stalled")

endmodule
